// ===== rtl/core/rbe_pkg.sv =====
// Shared constants and types for the region boundary edge extractor.
`default_nettype none

package rbe_pkg;

   localparam int DEF_MAX_COLOURS = 32;
   localparam int DEF_COORD_BITS  = 12;

   localparam int OP_BITS     = 1;
   localparam int COLOUR_BITS = 5;
   localparam int COUNT_BITS  = 6;
   localparam int CORNER_BITS = 32;
   localparam int WEIGHT_BITS = 16;
   localparam int PAIR_BITS   = 10;
   // lo + (count - 1) * hi with 5-bit colours and a 6-bit count stays below 2048
   localparam int INDEX_BITS  = 11;
   localparam int EPOCH_BITS  = 4;

   localparam logic [OP_BITS-1:0] OP_PIXEL = 1'b0;
   localparam logic [OP_BITS-1:0] OP_CLEAR = 1'b1;

   localparam logic [COUNT_BITS-1:0]  COUNT_RESET = 6'd32;
   localparam logic [CORNER_BITS-1:0] PURE_RED    = 32'hFFFF_0000;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_NONE = 16'd62128;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE  = 16'd53019;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_TWO  = 16'd43909;

   typedef enum logic [1:0] {
      KIND_QUIET = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_ERROR = 2'd2,
      KIND_EDGE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [EPOCH_BITS-1:0] epoch;
      logic [PAIR_BITS-1:0]  id;
   } entry_type;

   typedef struct packed {
      logic                  rd_en;
      logic [INDEX_BITS-1:0] rd_index;
      logic                  commit_edge;
      logic                  commit_clear;
      logic                  clear_waiting;
   } tab_req_type;

   typedef struct packed {
      logic                 hold;
      logic [PAIR_BITS-1:0] pair_id;
      logic                 new_pair;
   } tab_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/rbe_if.sv =====
// Valid/ready channel interfaces for pixel words and edge words.
`default_nettype none

interface rbe_req_if #(
   parameter int COORD_BITS = rbe_pkg::DEF_COORD_BITS
) ();
   logic                             valid;
   logic                             ready;
   logic [rbe_pkg::OP_BITS-1:0]      operation;
   logic                             line_start;
   logic                             vertical_pass;
   logic [COORD_BITS-1:0]            pixel_x;
   logic [COORD_BITS-1:0]            pixel_y;
   logic [rbe_pkg::COLOUR_BITS-1:0]  colour_index;
   logic [rbe_pkg::CORNER_BITS-1:0]  corner_a_colour;
   logic [rbe_pkg::CORNER_BITS-1:0]  corner_b_colour;

   modport source (
      output valid, operation, line_start, vertical_pass, pixel_x, pixel_y,
             colour_index, corner_a_colour, corner_b_colour,
      input  ready
   );
   modport sink (
      input  valid, operation, line_start, vertical_pass, pixel_x, pixel_y,
             colour_index, corner_a_colour, corner_b_colour,
      output ready
   );
endinterface

interface rbe_rsp_if #(
   parameter int COORD_BITS = rbe_pkg::DEF_COORD_BITS
) ();
   logic                             valid;
   logic                             ready;
   logic [rbe_pkg::PAIR_BITS-1:0]    pair_id;
   logic                             new_pair;
   logic [COORD_BITS-1:0]            low_side_x;
   logic [COORD_BITS-1:0]            low_side_y;
   logic [COORD_BITS-1:0]            high_side_x;
   logic [COORD_BITS-1:0]            high_side_y;
   logic [rbe_pkg::WEIGHT_BITS-1:0]  edge_weight;
   logic                             error;

   modport source (
      output valid, pair_id, new_pair, low_side_x, low_side_y, high_side_x,
             high_side_y, edge_weight, error,
      input  ready
   );
   modport sink (
      input  valid, pair_id, new_pair, low_side_x, low_side_y, high_side_x,
             high_side_y, edge_weight, error,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/region_boundary_edge_extractor_unit.sv =====
// Top level of the region boundary edge extractor.
//
//  channel   dir  handshake        word
//  req_chan  in   valid/ready      one pixel or a clear command
//  rsp_chan  out  valid/ready      one boundary edge or an error
//  csr_*     in   write enable     colour_count, 6 bits
//
// One word per cycle unless a table sweep or a stalled rsp_chan drops req_chan.ready; a result
// passes the lookup stage and then the output register. The pair table RAM read happens as a
// word is taken, the write-back as it leaves the lookup stage; a back-to-back repeat of a pair
// takes the id from the last-write register. After reset, and after every fifteenth clear, a
// sweep of the table holds req_chan.ready low.
// A stalled rsp_chan holds one edge in the output register and one in the
// lookup stage before req_chan.ready drops.
`default_nettype none

module region_boundary_edge_extractor_unit #(
   parameter int MAX_COLOURS = rbe_pkg::DEF_MAX_COLOURS,
   parameter int COORD_BITS  = rbe_pkg::DEF_COORD_BITS
) (
   input  wire                               clock,
   input  wire                               reset,
   rbe_req_if.sink                           req_chan,
   rbe_rsp_if.source                         rsp_chan,
   input  wire                               csr_write_enable,
   input  wire [rbe_pkg::COUNT_BITS-1:0]     csr_write_data
);

   localparam int TABLE_SIZE = MAX_COLOURS * (MAX_COLOURS - 1);

   logic [rbe_pkg::COUNT_BITS-1:0]  count_ff;
   logic [rbe_pkg::COLOUR_BITS-1:0] prev_ff, prev_in;

   logic                            s1_valid_ff, s1_valid_in;
   rbe_pkg::kind_type               s1_kind_ff, s1_kind_in;
   logic [COORD_BITS-1:0]           s1_lx_ff, s1_ly_ff, s1_hx_ff, s1_hy_ff;
   logic [COORD_BITS-1:0]           s1_lx_in, s1_ly_in, s1_hx_in, s1_hy_in;
   logic [rbe_pkg::WEIGHT_BITS-1:0] s1_weight_ff, s1_weight_in;

   logic                            out_valid_ff, out_valid_in;
   logic [rbe_pkg::PAIR_BITS-1:0]   out_id_ff, out_id_in;
   logic                            out_new_ff, out_new_in;
   logic [COORD_BITS-1:0]           out_lx_ff, out_ly_ff, out_hx_ff, out_hy_ff;
   logic [COORD_BITS-1:0]           out_lx_in, out_ly_in, out_hx_in, out_hy_in;
   logic [rbe_pkg::WEIGHT_BITS-1:0] out_weight_ff, out_weight_in;
   logic                            out_error_ff, out_error_in;

   logic [rbe_pkg::COUNT_BITS-1:0]  count_eff;
   logic [rbe_pkg::COLOUR_BITS-1:0] cur, lo, hi;
   logic                            cur_bad, prev_bad, index_bad, cur_low;
   logic [rbe_pkg::INDEX_BITS-1:0]  index;
   logic [COORD_BITS-1:0]           x, y, px, py;
   logic [1:0]                      red_corners;
   rbe_pkg::kind_type               kind;
   logic                            accept, s1_result, s1_go;

   rbe_pkg::tab_req_type            tab_req;
   rbe_pkg::tab_rsp_type            tab_rsp;

   // ---------------------------------------------------------------- decode
   assign count_eff = (32'(count_ff) > MAX_COLOURS) ?
                      rbe_pkg::COUNT_BITS'(MAX_COLOURS) : count_ff;
   assign cur       = req_chan.colour_index;
   assign cur_bad   = {1'b0, cur} >= count_eff;
   assign prev_bad  = {1'b0, prev_ff} >= count_eff;
   assign cur_low   = cur < prev_ff;
   assign lo        = cur_low ? cur : prev_ff;
   assign hi        = cur_low ? prev_ff : cur;
   assign index     = rbe_pkg::INDEX_BITS'(lo) +
                      rbe_pkg::INDEX_BITS'(count_eff - rbe_pkg::COUNT_BITS'(1)) *
                      rbe_pkg::INDEX_BITS'(hi);
   assign index_bad = 32'(index) >= TABLE_SIZE;

   assign x  = COORD_BITS'(req_chan.pixel_x);
   assign y  = COORD_BITS'(req_chan.pixel_y);
   assign px = req_chan.vertical_pass ? x : x - COORD_BITS'(1);
   assign py = req_chan.vertical_pass ? y - COORD_BITS'(1) : y;

   assign red_corners = 2'((req_chan.corner_a_colour == rbe_pkg::PURE_RED)) +
                        2'((req_chan.corner_b_colour == rbe_pkg::PURE_RED));

   always_comb begin
      if (req_chan.operation == rbe_pkg::OP_CLEAR) begin
         kind = rbe_pkg::KIND_CLEAR;
      end else if (cur_bad) begin
         kind = rbe_pkg::KIND_ERROR;
      end else if (req_chan.line_start || (cur == prev_ff)) begin
         kind = rbe_pkg::KIND_QUIET;
      end else if (prev_bad || index_bad) begin
         kind = rbe_pkg::KIND_ERROR;
      end else begin
         kind = rbe_pkg::KIND_EDGE;
      end
   end

   // ---------------------------------------------------------------- handshake
   always_comb begin
      case (s1_kind_ff)
         rbe_pkg::KIND_ERROR, rbe_pkg::KIND_EDGE: s1_result = 1'b1;
         default:                                 s1_result = 1'b0;
      endcase
   end

   assign s1_go  = s1_valid_ff && (!s1_result || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !tab_rsp.hold && (!s1_valid_ff || s1_go);
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      tab_req.rd_en         = accept && (kind == rbe_pkg::KIND_EDGE);
      tab_req.rd_index      = (kind == rbe_pkg::KIND_EDGE) ? index : '0;
      tab_req.commit_edge   = s1_go && (s1_kind_ff == rbe_pkg::KIND_EDGE);
      tab_req.commit_clear  = s1_go && (s1_kind_ff == rbe_pkg::KIND_CLEAR);
      tab_req.clear_waiting = s1_valid_ff && (s1_kind_ff == rbe_pkg::KIND_CLEAR);
   end

   rbe_pair_table #(
      .MAX_COLOURS (MAX_COLOURS)
   ) u_pair_table (
      .clock   (clock),
      .reset   (reset),
      .tab_req (tab_req),
      .tab_rsp (tab_rsp)
   );

   // ---------------------------------------------------------------- lookup stage
   always_comb begin
      prev_in      = prev_ff;
      s1_valid_in  = s1_valid_ff;
      s1_kind_in   = s1_kind_ff;
      s1_lx_in     = s1_lx_ff;
      s1_ly_in     = s1_ly_ff;
      s1_hx_in     = s1_hx_ff;
      s1_hy_in     = s1_hy_ff;
      s1_weight_in = s1_weight_ff;
      if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         if ((req_chan.operation == rbe_pkg::OP_PIXEL) && !cur_bad) begin
            prev_in = cur;
         end
         s1_valid_in = 1'b1;
         s1_kind_in  = kind;
         if (cur_low) begin
            s1_lx_in = x;
            s1_ly_in = y;
            s1_hx_in = px;
            s1_hy_in = py;
         end else begin
            s1_lx_in = px;
            s1_ly_in = py;
            s1_hx_in = x;
            s1_hy_in = y;
         end
         case (red_corners)
            2'd0:    s1_weight_in = rbe_pkg::WEIGHT_NONE;
            2'd1:    s1_weight_in = rbe_pkg::WEIGHT_ONE;
            default: s1_weight_in = rbe_pkg::WEIGHT_TWO;
         endcase
      end
   end

   // ---------------------------------------------------------------- output register
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_id_in     = out_id_ff;
      out_new_in    = out_new_ff;
      out_lx_in     = out_lx_ff;
      out_ly_in     = out_ly_ff;
      out_hx_in     = out_hx_ff;
      out_hy_in     = out_hy_ff;
      out_weight_in = out_weight_ff;
      out_error_in  = out_error_ff;
      if (s1_go && s1_result) begin
         out_valid_in = 1'b1;
         if (s1_kind_ff == rbe_pkg::KIND_EDGE) begin
            out_id_in     = tab_rsp.pair_id;
            out_new_in    = tab_rsp.new_pair;
            out_lx_in     = s1_lx_ff;
            out_ly_in     = s1_ly_ff;
            out_hx_in     = s1_hx_ff;
            out_hy_in     = s1_hy_ff;
            out_weight_in = s1_weight_ff;
            out_error_in  = 1'b0;
         end else begin
            out_id_in     = '0;
            out_new_in    = 1'b0;
            out_lx_in     = '0;
            out_ly_in     = '0;
            out_hx_in     = '0;
            out_hy_in     = '0;
            out_weight_in = '0;
            out_error_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff    <= s1_kind_in;
      s1_lx_ff      <= s1_lx_in;
      s1_ly_ff      <= s1_ly_in;
      s1_hx_ff      <= s1_hx_in;
      s1_hy_ff      <= s1_hy_in;
      s1_weight_ff  <= s1_weight_in;
      out_id_ff     <= out_id_in;
      out_new_ff    <= out_new_in;
      out_lx_ff     <= out_lx_in;
      out_ly_ff     <= out_ly_in;
      out_hx_ff     <= out_hx_in;
      out_hy_ff     <= out_hy_in;
      out_weight_ff <= out_weight_in;
      out_error_ff  <= out_error_in;
      if (reset) begin
         count_ff     <= rbe_pkg::COUNT_RESET;
         prev_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            count_ff <= csr_write_data;
         end
         prev_ff      <= prev_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.pair_id     = out_id_ff;
   assign rsp_chan.new_pair    = out_new_ff;
   assign rsp_chan.low_side_x  = out_lx_ff;
   assign rsp_chan.low_side_y  = out_ly_ff;
   assign rsp_chan.high_side_x = out_hx_ff;
   assign rsp_chan.high_side_y = out_hy_ff;
   assign rsp_chan.edge_weight = out_weight_ff;
   assign rsp_chan.error       = out_error_ff;

`ifndef SYNTHESIS
   a_no_accept_on_hold: assert property (@(posedge clock) disable iff (reset)
      accept |-> !tab_rsp.hold)
      else $error("word taken while table held");
   a_error_word_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_error_ff) |-> (out_id_ff == '0) && !out_new_ff &&
      (out_weight_ff == '0))
      else $error("error word carries edge data");
   a_stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> s1_valid_ff && $stable(s1_kind_ff) &&
      $stable(s1_weight_ff))
      else $error("lookup stage lost its word");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rbe_pair_table.sv =====
// Pair identifier table: epoch-tagged RAM, read-modify-write with forwarding.
`default_nettype none

module rbe_pair_table #(
   parameter int MAX_COLOURS = rbe_pkg::DEF_MAX_COLOURS
) (
   input  wire                  clock,
   input  wire                  reset,
   input  rbe_pkg::tab_req_type tab_req,
   output rbe_pkg::tab_rsp_type tab_rsp
);

   localparam int TABLE_SIZE = MAX_COLOURS * (MAX_COLOURS - 1);
   // indexes never reach beyond the index width, so the RAM stops there
   localparam int DEPTH  = (TABLE_SIZE < (1 << rbe_pkg::INDEX_BITS)) ?
                           TABLE_SIZE : (1 << rbe_pkg::INDEX_BITS);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [rbe_pkg::EPOCH_BITS-1:0] EPOCH_FIRST = rbe_pkg::EPOCH_BITS'(1);
   localparam logic [rbe_pkg::EPOCH_BITS-1:0] EPOCH_LAST  = '1;

   rbe_pkg::entry_type mem [DEPTH];

   rbe_pkg::entry_type              rd_ff;
   logic [ADDR_W-1:0]               look_addr_ff, look_addr_in;
   logic [rbe_pkg::EPOCH_BITS-1:0]  epoch_ff, epoch_in;
   logic [rbe_pkg::PAIR_BITS-1:0]   counter_ff, counter_in;
   logic                            busy_ff, busy_in;
   logic [ADDR_W-1:0]               pass_addr_ff, pass_addr_in;
   logic                            lw_valid_ff, lw_valid_in;
   logic [ADDR_W-1:0]               lw_addr_ff, lw_addr_in;
   rbe_pkg::entry_type              lw_entry_ff, lw_entry_in;

   logic                            fwd, hit, wr_en;
   logic [ADDR_W-1:0]               wr_addr, rd_addr;
   rbe_pkg::entry_type              wr_data;

   assign rd_addr = ADDR_W'(tab_req.rd_index);

   // last write covers the read that was issued on the same edge
   assign fwd = lw_valid_ff && (lw_addr_ff == look_addr_ff) &&
                (lw_entry_ff.epoch == epoch_ff);
   assign hit = fwd || (rd_ff.epoch == epoch_ff);

   always_comb begin
      tab_rsp.hold     = busy_ff || (tab_req.clear_waiting && (epoch_ff == EPOCH_LAST));
      tab_rsp.new_pair = !hit;
      if (fwd) begin
         tab_rsp.pair_id = lw_entry_ff.id;
      end else if (hit) begin
         tab_rsp.pair_id = rd_ff.id;
      end else begin
         tab_rsp.pair_id = counter_ff;
      end
   end

   always_comb begin
      wr_en   = busy_ff || (tab_req.commit_edge && !hit);
      wr_addr = busy_ff ? pass_addr_ff : look_addr_ff;
      wr_data = busy_ff ? '0 : rbe_pkg::entry_type'{epoch: epoch_ff, id: counter_ff};
   end

   always_comb begin
      look_addr_in = tab_req.rd_en ? rd_addr : look_addr_ff;
      epoch_in     = epoch_ff;
      counter_in   = counter_ff;
      busy_in      = busy_ff;
      pass_addr_in = pass_addr_ff;
      lw_valid_in  = lw_valid_ff;
      lw_addr_in   = lw_addr_ff;
      lw_entry_in  = lw_entry_ff;
      if (busy_ff) begin
         lw_valid_in  = 1'b0;
         pass_addr_in = pass_addr_ff + ADDR_W'(1);
         if (pass_addr_ff == ADDR_W'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end else if (wr_en) begin
         lw_valid_in = 1'b1;
         lw_addr_in  = wr_addr;
         lw_entry_in = wr_data;
         counter_in  = counter_ff + rbe_pkg::PAIR_BITS'(1);
      end
      if (tab_req.commit_clear) begin
         counter_in = '0;
         if (epoch_ff == EPOCH_LAST) begin
            // epoch tags run out: sweep the RAM back to the empty tag
            busy_in      = 1'b1;
            pass_addr_in = '0;
            epoch_in     = EPOCH_FIRST;
         end else begin
            epoch_in = epoch_ff + rbe_pkg::EPOCH_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (tab_req.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      look_addr_ff <= look_addr_in;
      lw_addr_ff   <= lw_addr_in;
      lw_entry_ff  <= lw_entry_in;
      if (reset) begin
         epoch_ff     <= EPOCH_FIRST;
         counter_ff   <= '0;
         busy_ff      <= 1'b1;
         pass_addr_ff <= '0;
         lw_valid_ff  <= 1'b0;
      end else begin
         epoch_ff     <= epoch_in;
         counter_ff   <= counter_in;
         busy_ff      <= busy_in;
         pass_addr_ff <= pass_addr_in;
         lw_valid_ff  <= lw_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_no_edge_in_sweep: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !tab_req.commit_edge && !tab_req.rd_en)
      else $error("pair table used during sweep");
   a_clear_zeroes_counter: assert property (@(posedge clock) disable iff (reset)
      tab_req.commit_clear |=> counter_ff == '0)
      else $error("pair counter not cleared");
   a_sweep_ends_first_epoch: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> epoch_ff == EPOCH_FIRST)
      else $error("sweep left a stale epoch");
`endif

endmodule

`default_nettype wire
